@@ rtl/core/fdtd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdtd_pkg: shared types and constants for the 1D Yee field update unit
// Command/result payloads, register indexes, reset values, saturation helper.
// ----------------------------------------------------------------------------
package fdtd_pkg;

  localparam int unsigned CellsDef  = 256;
  localparam int unsigned FieldW    = 32;
  localparam int unsigned CoeffW    = 18;
  localparam int unsigned CellIdxW  = 8;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 18;

  localparam logic [CoeffW-1:0]   ECoeffRst = 18'd32768;
  localparam logic [CoeffW-1:0]   HCoeffRst = 18'd32768;
  localparam logic [CellIdxW-1:0] SrcCellRst = 8'd64;

  // command kinds
  localparam logic KindStep = 1'b0;
  localparam logic KindRead = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_E_COEFF  = 2'd0,
    REG_H_COEFF  = 2'd1,
    REG_SRC_CELL = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic                     kind;
    logic signed [FieldW-1:0] source_value;
    logic [CellIdxW-1:0]      cell_index;
  } cmd_t;

  typedef struct packed {
    logic signed [FieldW-1:0] e_value;
    logic signed [FieldW-1:0] h_value;
    logic signed [FieldW-1:0] peak_e;
  } result_t;

  // clamp a 37-bit signed sum to the signed 32-bit range
  function automatic logic signed [FieldW-1:0] sat_s32(input logic signed [36:0] v);
    logic signed [FieldW-1:0] r;
    if (v > 37'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -37'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[FieldW-1:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/core/fdtd_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdtd_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fdtd_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/fdtd_1d_yee_field_update_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdtd_1d_yee_field_update_unit: 1D Yee grid leapfrog field update
// Holds CELLS electric and magnetic cells (signed Q16.16) in two RAMs and
// runs H and E sweeps through one shared multiply/round/saturate datapath.
// ----------------------------------------------------------------------------
//
//  channel | signals                                        | dir | transfer when
//  --------+------------------------------------------------+-----+--------------------------
//  command | start, busy, cmd_i                             | in  | start && !busy
//  result  | done_o, result_o                               | out | done_o (one cycle)
//  config  | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i | in  | cfg_valid_i && cfg_ready_o
//
// A read goes to S_READ; the RAM read data is then registered into result_o with done_o.
// A step keeps busy high through CELLS H reads and CELLS E reads,
// one per cycle, each sweep then draining the 4-deep datapath (read, diff, mul, add).
// Reset: both field RAMs are cleared by a pass over all CELLS cells; busy stays high.
// Config writes are always taken (ready tied high).
// The receiver cannot stall: each result shows for exactly one cycle.
// ----------------------------------------------------------------------------
module fdtd_1d_yee_field_update_unit #(
  parameter int unsigned CELLS = fdtd_pkg::CellsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // command
  input  logic                              start,
  output logic                              busy,
  input  fdtd_pkg::cmd_t                    cmd_i,
  // result
  output logic                              done_o,
  output fdtd_pkg::result_t                 result_o,
  // configuration
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [fdtd_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [fdtd_pkg::CfgDataW-1:0]     cfg_data_i
);

  localparam int unsigned AW = $clog2(CELLS);
  localparam logic [AW-1:0] LastIdx = AW'(CELLS - 1);

  // sequencer states
  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_HPASS  = 7'b0000100,
    S_HDRAIN = 7'b0001000,
    S_EPASS  = 7'b0010000,
    S_EDRAIN = 7'b0100000,
    S_READ   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [AW-1:0] cnt_q, cnt_d;

  // ---------------------------------------------------------------- config
  logic [fdtd_pkg::CoeffW-1:0]   e_coeff_q, h_coeff_q;
  logic [fdtd_pkg::CellIdxW-1:0] src_cell_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_coeff_q  <= fdtd_pkg::ECoeffRst;
      h_coeff_q  <= fdtd_pkg::HCoeffRst;
      src_cell_q <= fdtd_pkg::SrcCellRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        fdtd_pkg::REG_E_COEFF:  e_coeff_q  <= cfg_data_i[fdtd_pkg::CoeffW-1:0];
        fdtd_pkg::REG_H_COEFF:  h_coeff_q  <= cfg_data_i[fdtd_pkg::CoeffW-1:0];
        fdtd_pkg::REG_SRC_CELL: src_cell_q <= cfg_data_i[fdtd_pkg::CellIdxW-1:0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // ---------------------------------------------------------------- RAMs
  logic          e_we, h_we;
  logic [AW-1:0] e_waddr, h_waddr, e_raddr, h_raddr;
  logic [fdtd_pkg::FieldW-1:0] e_wdata, h_wdata, e_rdata, h_rdata;

  fdtd_ram #(.Width(fdtd_pkg::FieldW), .Depth(CELLS)) u_e_ram (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (e_waddr),
    .wdata_i (e_wdata),
    .raddr_i (e_raddr),
    .rdata_o (e_rdata)
  );

  fdtd_ram #(.Width(fdtd_pkg::FieldW), .Depth(CELLS)) u_h_ram (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (h_waddr),
    .wdata_i (h_wdata),
    .raddr_i (h_raddr),
    .rdata_o (h_rdata)
  );

  // ---------------------------------------------------------------- datapath
  // issue stage meta travels with the registered RAM read
  logic          iss_v_q, iss_e_q, iss_first_q;
  logic [AW-1:0] iss_idx_q;
  // difference stage
  logic          dif_v_q, dif_e_q;
  logic [AW-1:0] dif_idx_q;
  logic signed [32:0] dif_q;
  logic signed [fdtd_pkg::FieldW-1:0] dif_tgt_q, prev_q;
  // multiply stage
  logic          mul_v_q, mul_e_q;
  logic [AW-1:0] mul_idx_q;
  logic signed [51:0] prod_q;
  logic signed [fdtd_pkg::FieldW-1:0] mul_tgt_q;
  // round/accumulate stage
  logic          sum_v_q, sum_e_q;
  logic [AW-1:0] sum_idx_q;
  logic signed [fdtd_pkg::FieldW-1:0] sum_q;

  logic signed [fdtd_pkg::FieldW-1:0] src_q, peak_q;
  logic        rd_in_range_q;

  logic        issue;
  logic        pipe_empty;

  assign issue      = (state_q == S_HPASS) || (state_q == S_EPASS);
  assign pipe_empty = !(iss_v_q || dif_v_q || mul_v_q || sum_v_q);

  // read addresses: H sweep pairs e[k] with h[k-1]; E sweep uses h[k], e[k]
  always_comb begin
    unique case (state_q)
      S_HPASS: begin
        e_raddr = cnt_q;
        h_raddr = cnt_q - AW'(1);
      end
      S_EPASS: begin
        e_raddr = cnt_q;
        h_raddr = cnt_q;
      end
      default: begin
        e_raddr = AW'(cmd_i.cell_index);
        h_raddr = AW'(cmd_i.cell_index);
      end
    endcase
  end

  // difference stage logic
  logic signed [fdtd_pkg::FieldW-1:0] cur_src, cur_tgt;
  logic signed [32:0] dif_d;
  assign cur_src = iss_e_q ? h_rdata : e_rdata;
  assign cur_tgt = iss_e_q ? e_rdata : h_rdata;
  assign dif_d   = iss_first_q ? 33'sd0
                 : ($signed({cur_src[31], cur_src}) - $signed({prev_q[31], prev_q}));

  // multiply stage: 33 x 19 signed
  logic signed [18:0] coeff_s;
  logic signed [51:0] prod_d;
  assign coeff_s = $signed({1'b0, (dif_e_q ? e_coeff_q : h_coeff_q)});
  assign prod_d  = dif_q * coeff_s;

  // round half up to Q16.16, add to old cell value, saturate
  logic signed [51:0] rnd;
  logic signed [35:0] scaled;
  logic signed [36:0] acc;
  assign rnd    = prod_q + 52'sd32768;
  assign scaled = rnd[51:16];
  assign acc    = $signed({{5{mul_tgt_q[31]}}, mul_tgt_q}) + $signed({scaled[35], scaled});

  // soft source add on the E write path
  logic        src_hit;
  logic signed [36:0] src_acc;
  logic signed [fdtd_pkg::FieldW-1:0] e_final;
  assign src_hit = sum_e_q && (32'(sum_idx_q) == 32'(src_cell_q));
  assign src_acc = $signed({{5{sum_q[31]}}, sum_q}) + $signed({{5{src_q[31]}}, src_q});
  assign e_final = src_hit ? fdtd_pkg::sat_s32(src_acc) : sum_q;

  // write ports: clear pass or end of the datapath
  always_comb begin
    if (state_q == S_CLEAR) begin
      e_we    = 1'b1;
      h_we    = 1'b1;
      e_waddr = cnt_q;
      h_waddr = cnt_q;
      e_wdata = '0;
      h_wdata = '0;
    end else begin
      e_we    = sum_v_q && sum_e_q;
      h_we    = sum_v_q && !sum_e_q;
      e_waddr = sum_idx_q;
      h_waddr = sum_idx_q;
      e_wdata = e_final;
      h_wdata = sum_q;
    end
  end

  // pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iss_v_q <= 1'b0;
      dif_v_q <= 1'b0;
      mul_v_q <= 1'b0;
      sum_v_q <= 1'b0;
    end else begin
      iss_v_q <= issue;
      dif_v_q <= iss_v_q && (iss_e_q || !iss_first_q);
      mul_v_q <= dif_v_q;
      sum_v_q <= mul_v_q;
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    iss_e_q     <= (state_q == S_EPASS);
    iss_first_q <= (cnt_q == '0);
    iss_idx_q   <= (state_q == S_EPASS) ? cnt_q : (cnt_q - AW'(1));
    if (iss_v_q) begin
      prev_q <= cur_src;
    end
    dif_e_q   <= iss_e_q;
    dif_idx_q <= iss_idx_q;
    dif_q     <= dif_d;
    dif_tgt_q <= cur_tgt;
    mul_e_q   <= dif_e_q;
    mul_idx_q <= dif_idx_q;
    prod_q    <= prod_d;
    mul_tgt_q <= dif_tgt_q;
    sum_e_q   <= mul_e_q;
    sum_idx_q <= mul_idx_q;
    sum_q     <= fdtd_pkg::sat_s32(acc);
    // peak over the final E values, cell 0 written first
    if (sum_v_q && sum_e_q) begin
      if (sum_idx_q == '0 || e_final > peak_q) begin
        peak_q <= e_final;
      end
    end
    if (start && !busy) begin
      src_q         <= cmd_i.source_value;
      rd_in_range_q <= (32'(cmd_i.cell_index) < 32'(CELLS));
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      S_CLEAR: begin
        cnt_d = cnt_q + AW'(1);
        if (cnt_q == LastIdx) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cnt_d   = '0;
          state_d = (cmd_i.kind == fdtd_pkg::KindRead) ? S_READ : S_HPASS;
        end
      end
      S_HPASS: begin
        cnt_d = cnt_q + AW'(1);
        if (cnt_q == LastIdx) begin
          cnt_d   = '0;
          state_d = S_HDRAIN;
        end
      end
      S_HDRAIN: begin
        if (pipe_empty) begin
          state_d = S_EPASS;
        end
      end
      S_EPASS: begin
        cnt_d = cnt_q + AW'(1);
        if (cnt_q == LastIdx) begin
          cnt_d   = '0;
          state_d = S_EDRAIN;
        end
      end
      S_EDRAIN: begin
        if (pipe_empty) begin
          state_d = S_IDLE;
        end
      end
      S_READ: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign busy = (state_q != S_IDLE);

  // ---------------------------------------------------------------- result
  logic done_q;
  fdtd_pkg::result_t result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= (state_q == S_READ) || ((state_q == S_EDRAIN) && pipe_empty);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_READ) begin
      result_q.e_value <= rd_in_range_q ? e_rdata : '0;
      result_q.h_value <= rd_in_range_q ? h_rdata : '0;
      result_q.peak_e  <= '0;
    end else if ((state_q == S_EDRAIN) && pipe_empty) begin
      result_q.e_value <= '0;
      result_q.h_value <= '0;
      result_q.peak_e  <= peak_q;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

@@ test/fdtd_1d_yee_field_update_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdtd_1d_yee_field_update_unit_tb: self-checking bench for the 1D Yee update
// Drives step and read commands with random idle gaps, retunes the Courant
// coefficients and source cell between phases, and checks every result
// against a bit-exact leapfrog grid model kept inside the bench.
// ----------------------------------------------------------------------------
module fdtd_1d_yee_field_update_unit_tb;
  import fdtd_pkg::*;

  localparam int unsigned ClkPeriod   = 8;
  localparam int unsigned ResetCycles = 4;
  localparam int unsigned TailCycles  = 40;
  // Quiet-cycle limit. The longest correct quiet stretch is a long sender gap
  // plus one step sweep, or the clear pass after reset. Several times that.
  localparam int unsigned QuietLimit  = 20000;
  localparam int unsigned ReportMax   = 10;
  localparam int unsigned PhaseCount  = 9;
  localparam int unsigned PhaseItems  = 128;
  // data bits above the cell index in a source-cell register write
  localparam int unsigned SrcPadW     = CfgDataW - CellIdxW;

  // register index past the end of the map; writes to it must be ignored
  localparam logic [CfgIdxW-1:0] RegSpare = 2'd3;

  localparam logic signed [FieldW-1:0] FieldMax = 32'sh7FFF_FFFF;
  localparam logic signed [FieldW-1:0] FieldMin = 32'sh8000_0000;

  typedef enum logic [1:0] {
    PLAN_CMD,   // one command transfer
    PLAN_CFG,   // one register write, only once the unit has gone quiet
    PLAN_SYNC   // hold off until every result in flight has come back
  } plan_op_e;

  typedef struct {
    plan_op_e              op;
    cmd_t                  cmd;
    logic [CfgIdxW-1:0]    reg_idx;
    logic [CfgDataW-1:0]   reg_val;
    int unsigned           gap;
  } plan_t;

  // --------------------------------------------------------------------------
  // DUT hookup; every input has a known value from time zero
  // --------------------------------------------------------------------------
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  start       = 1'b0;
  logic                  busy;
  cmd_t                  cmd_i       = '0;
  logic                  done_o;
  result_t               result_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CfgIdxW-1:0]    cfg_index_i = '0;
  logic [CfgDataW-1:0]   cfg_data_i  = '0;

  fdtd_1d_yee_field_update_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Grid model: own copy of both field arrays and the three registers
  // --------------------------------------------------------------------------
  logic signed [FieldW-1:0] e_grid [CellsDef];
  logic signed [FieldW-1:0] h_grid [CellsDef];
  logic [CoeffW-1:0]        e_coef   = ECoeffRst;
  logic [CoeffW-1:0]        h_coef   = HCoeffRst;
  logic [CellIdxW-1:0]      src_cell = SrcCellRst;

  result_t yee_results_q [$];   // predicted results, oldest first
  plan_t   cmd_plan_q [$];      // commands/writes not yet handed to the unit

  // bench bookkeeping
  int unsigned fail_count  = 0;
  int unsigned quiet_count = 0;
  int unsigned burst_left  = 0;
  int unsigned gap_left    = 0;
  bit          plan_ready  = 1'b0;
  bit          presenting  = 1'b0;
  bit          xfer_seen   = 1'b0;
  bit          finished    = 1'b0;
  bit          timed_out   = 1'b0;
  plan_t       drv_item;

  function automatic logic signed [FieldW-1:0] clamp_s32(input longint v);
    if (v > longint'(FieldMax)) return FieldMax;
    if (v < longint'(FieldMin)) return FieldMin;
    return v[FieldW-1:0];
  endfunction

  // diff * coeff is Q32; add half an LSB and floor back to Q16
  function automatic longint scale_diff(input longint d, input logic [CoeffW-1:0] c);
    longint t;
    t = d * longint'(c) + 64'sd32768;
    return t >>> 16;
  endfunction

  // Advance or read the model for one accepted command; returns its result.
  function automatic result_t yee_predict(input cmd_t c);
    result_t                  r;
    longint                   d;
    logic signed [FieldW-1:0] peak;
    r = '0;
    if (c.kind == KindRead) begin
      r.e_value = e_grid[c.cell_index];
      r.h_value = h_grid[c.cell_index];
    end else begin
      // H from old E, every cell but the last
      for (int i = 0; i < CellsDef - 1; i++) begin
        d = longint'(e_grid[i + 1]) - longint'(e_grid[i]);
        h_grid[i] = clamp_s32(longint'(h_grid[i]) + scale_diff(d, h_coef));
      end
      // E from new H, every cell but the first
      for (int i = 1; i < CellsDef; i++) begin
        d = longint'(h_grid[i]) - longint'(h_grid[i - 1]);
        e_grid[i] = clamp_s32(longint'(e_grid[i]) + scale_diff(d, e_coef));
      end
      // soft source; an 8-bit index is always inside a 256-cell grid
      e_grid[src_cell] = clamp_s32(longint'(e_grid[src_cell]) + longint'(c.source_value));
      peak = e_grid[0];
      for (int i = 1; i < CellsDef; i++) begin
        if (e_grid[i] > peak) peak = e_grid[i];
      end
      r.peak_e = peak;
    end
    return r;
  endfunction

  task automatic check_field(input string fname, input logic signed [FieldW-1:0] want,
                             input logic signed [FieldW-1:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= ReportMax) begin
        $display("[%0t] %s mismatch: expected %0d (0x%08h), got %0d (0x%08h)",
                 $time, fname, want, want, got, got);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus plan helpers
  // --------------------------------------------------------------------------
  // Mostly back-to-back or short gaps, some medium, a few long enough to land
  // anywhere in (or past) a full step sweep; now and then a run with no gaps.
  function automatic int unsigned draw_gap();
    int unsigned roll;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 20);
    return $urandom_range(21, 700);
  endfunction

  task automatic push_cmd(input logic kind, input logic signed [FieldW-1:0] srcv,
                          input logic [CellIdxW-1:0] idx);
    plan_t p;
    p.op               = PLAN_CMD;
    p.cmd.kind         = kind;
    p.cmd.source_value = srcv;
    p.cmd.cell_index   = idx;
    p.reg_idx          = '0;
    p.reg_val          = '0;
    p.gap              = draw_gap();
    cmd_plan_q.push_back(p);
  endtask

  task automatic push_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    plan_t p;
    p.op      = PLAN_CFG;
    p.cmd     = '0;
    p.reg_idx = idx;
    p.reg_val = val;
    p.gap     = draw_gap();
    cmd_plan_q.push_back(p);
  endtask

  task automatic push_sync();
    plan_t p;
    p.op      = PLAN_SYNC;
    p.cmd     = '0;
    p.reg_idx = '0;
    p.reg_val = '0;
    p.gap     = draw_gap();
    cmd_plan_q.push_back(p);
  endtask

  // step source sample: mostly a few field units, some full-range, some extremes
  function automatic logic signed [FieldW-1:0] draw_source();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return int'($urandom_range(0, 524288)) - 262144;
    if (roll < 85) return $urandom;
    case ($urandom_range(0, 4))
      0:       return FieldMax;
      1:       return FieldMin;
      2:       return 32'sd0;
      3:       return -32'sd1;
      default: return 32'sd1;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Driver: presents one planned transfer at a time, changes on falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (presenting && xfer_seen) begin
        presenting = 1'b0;
        gap_left   = (cmd_plan_q.size() > 0) ? cmd_plan_q[0].gap : 0;
      end
      xfer_seen = 1'b0;
      if (!presenting) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_plan_q.size() > 0) begin
          // register writes and sync points wait for a quiet unit
          if (cmd_plan_q[0].op == PLAN_CMD || (yee_results_q.size() == 0 && !busy)) begin
            drv_item = cmd_plan_q.pop_front();
            if (drv_item.op == PLAN_SYNC) begin
              gap_left = (cmd_plan_q.size() > 0) ? cmd_plan_q[0].gap : 0;
            end else begin
              presenting = 1'b1;
            end
          end
        end
      end
      // one nonblocking update per signal per edge, so a held start stays high
      start       <= presenting && (drv_item.op == PLAN_CMD);
      cfg_valid_i <= presenting && (drv_item.op == PLAN_CFG);
      if (presenting) begin
        cmd_i       <= drv_item.cmd;
        cfg_index_i <= drv_item.reg_idx;
        cfg_data_i  <= drv_item.reg_val;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: samples on rising edge, predicts on command transfer, checks
  // results, applies register writes, and runs the quiet-cycle watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        yee_results_q.push_back(yee_predict(cmd_i));
        xfer_seen = 1'b1;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_E_COEFF:  e_coef   = cfg_data_i[CoeffW-1:0];
          REG_H_COEFF:  h_coef   = cfg_data_i[CoeffW-1:0];
          REG_SRC_CELL: src_cell = cfg_data_i[CellIdxW-1:0];
          default: ;
        endcase
        xfer_seen = 1'b1;
      end
      if (done_o) begin
        if (yee_results_q.size() == 0) begin
          fail_count++;
          if (fail_count <= ReportMax) begin
            $display("[%0t] result with nothing outstanding: e %0d h %0d peak %0d",
                     $time, result_o.e_value, result_o.h_value, result_o.peak_e);
          end
        end else begin
          result_t want;
          want = yee_results_q.pop_front();
          check_field("e_value", want.e_value, result_o.e_value);
          check_field("h_value", want.h_value, result_o.h_value);
          check_field("peak_e",  want.peak_e,  result_o.peak_e);
        end
      end
      if ((start && !busy) || (cfg_valid_i && cfg_ready_o) || done_o) begin
        quiet_count = 0;
      end else begin
        quiet_count++;
        if (quiet_count >= QuietLimit) timed_out = 1'b1;
      end
      finished = plan_ready && cmd_plan_q.size() == 0 && !presenting &&
                 yee_results_q.size() == 0;
    end
  end

  // --------------------------------------------------------------------------
  // Plan, reset, and end of run
  // --------------------------------------------------------------------------
  initial begin
    logic [CoeffW-1:0]   ec, hc;
    logic [CellIdxW-1:0] sc;
    int unsigned         roll;

    foreach (e_grid[i]) begin
      e_grid[i] = '0;
      h_grid[i] = '0;
    end

    // Directed: empty grid reads at both ends, a zero step, positive and
    // negative saturation at the source, reads around it, a write to the
    // unmapped register, and the source moved to both edge cells.
    push_cmd(KindRead, 32'sd0, 8'd0);
    push_cmd(KindRead, FieldMax, 8'd255);
    push_cmd(KindStep, 32'sd0, 8'd0);
    push_cmd(KindStep, FieldMax, 8'd255);
    push_cmd(KindStep, FieldMax, 8'd0);
    push_cmd(KindRead, 32'sd0, 8'd64);
    push_cmd(KindRead, 32'sd0, 8'd63);
    push_cmd(KindRead, 32'sd0, 8'd65);
    push_cmd(KindStep, FieldMin, 8'd0);
    push_cmd(KindStep, FieldMin, 8'd0);
    push_cmd(KindStep, FieldMin, 8'd0);
    push_cmd(KindRead, 32'sd0, 8'd64);
    push_cmd(KindRead, 32'sd0, 8'd66);
    push_cfg(RegSpare, '1);
    push_cfg(REG_SRC_CELL, 18'd255);
    push_cmd(KindStep, 32'sd12345, 8'd0);
    push_cmd(KindRead, 32'sd0, 8'd255);
    push_cmd(KindRead, 32'sd0, 8'd254);
    push_cfg(REG_SRC_CELL, 18'd0);
    push_cmd(KindStep, -32'sd65536, 8'd0);
    push_cmd(KindRead, 32'sd0, 8'd0);
    push_cmd(KindRead, 32'sd0, 8'd1);

    // Random phases. Stable settings first, then zero coefficients, then the
    // largest ones last since those drive the grid into saturation for good.
    for (int ph = 0; ph < PhaseCount; ph++) begin
      case (ph)
        0:       begin ec = ECoeffRst; hc = HCoeffRst; sc = SrcCellRst; end
        1:       begin ec = CoeffW'($urandom_range(16384, 65535));
                       hc = CoeffW'($urandom_range(16384, 65535));
                       sc = CellIdxW'($urandom); end
        2:       begin ec = 18'd65536; hc = 18'd65536; sc = 8'd0; end
        3:       begin ec = CoeffW'($urandom_range(0, 8191));
                       hc = CoeffW'($urandom_range(0, 8191));
                       sc = 8'd255; end
        4:       begin ec = '0; hc = 18'd32768; sc = CellIdxW'($urandom); end
        5:       begin ec = 18'd32768; hc = '0; sc = CellIdxW'($urandom); end
        6:       begin ec = '0; hc = '0; sc = CellIdxW'($urandom); end
        7:       begin ec = CoeffW'($urandom); hc = CoeffW'($urandom);
                       sc = CellIdxW'($urandom); end
        default: begin ec = '1; hc = '1; sc = CellIdxW'($urandom); end
      endcase
      push_sync();
      push_cfg(REG_E_COEFF, ec);
      push_cfg(REG_H_COEFF, hc);
      // upper data bits are don't-care for the cell register; toggle them too
      push_cfg(REG_SRC_CELL, {SrcPadW'($urandom), sc});
      if (ph == 3) push_cfg(RegSpare, CfgDataW'($urandom));
      for (int n = 0; n < PhaseItems; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 2) push_sync();
        if (roll < 45) begin
          push_cmd(KindStep, draw_source(), CellIdxW'($urandom));
        end else if (roll < 75) begin
          // around the source, where the pulse lives
          push_cmd(KindRead, $urandom, sc + CellIdxW'($urandom_range(0, 8)) - 8'd4);
        end else begin
          push_cmd(KindRead, $urandom, CellIdxW'($urandom));
        end
      end
    end
    plan_ready = 1'b1;

    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (finished || timed_out);
    if (!timed_out) repeat (TailCycles) @(posedge clk_i);
    if (!timed_out && fail_count == 0 && yee_results_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
